@@ hdl/sbckd_pkg.sv @@
// shared constants, register indexes and translation tables for the code key decoder
package sbckd_pkg;

    localparam int COUNT_W     = 8;
    localparam int CODE_W      = 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int TABLE_SIZE  = 32;
    localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [CODE_W-1:0] KEY_NONE      = 8'd1;
    localparam logic [CODE_W-1:0] KEY_NUM_MODE  = 8'd6;
    localparam logic [CODE_W-1:0] KEY_ALPHA_MODE = 8'd7;

    localparam logic [CFG_W-1:0] DOT_PERIOD_RST         = 8'd2;
    localparam logic [CFG_W-1:0] DASH_PERIOD_RST        = 8'd11;
    localparam logic [CFG_W-1:0] MODE_SWITCH_PERIOD_RST = 8'd110;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_PERIOD         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_PERIOD        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_SWITCH_PERIOD = 2'd2;

    function automatic logic [CODE_W-1:0] alpha_rom(input logic [TABLE_IDX_W-1:0] idx);
        logic [CODE_W-1:0] ch;
        case (idx)
            5'd0:  ch = 8'd0;
            5'd1:  ch = 8'd1;
            5'd2:  ch = 8'h2e;
            5'd3:  ch = 8'h20;
            5'd4:  ch = 8'h53;
            5'd5:  ch = 8'h5a;
            5'd6:  ch = 8'd6;
            5'd7:  ch = 8'd7;
            5'd8:  ch = 8'h54;
            5'd9:  ch = 8'h57;
            5'd10: ch = 8'h41;
            5'd11: ch = 8'h44;
            5'd12: ch = 8'h47;
            5'd13: ch = 8'h4a;
            5'd14: ch = 8'h4d;
            5'd15: ch = 8'h50;
            5'd16: ch = 8'h55;
            5'd17: ch = 8'h56;
            5'd18: ch = 8'h58;
            5'd19: ch = 8'h59;
            5'd20: ch = 8'h42;
            5'd21: ch = 8'h43;
            5'd22: ch = 8'h45;
            5'd23: ch = 8'h46;
            5'd24: ch = 8'h48;
            5'd25: ch = 8'h49;
            5'd26: ch = 8'h4b;
            5'd27: ch = 8'h4c;
            5'd28: ch = 8'h4e;
            5'd29: ch = 8'h4f;
            5'd30: ch = 8'h51;
            5'd31: ch = 8'h52;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [CODE_W-1:0] num_rom(input logic [TABLE_IDX_W-1:0] idx);
        logic [CODE_W-1:0] ch;
        case (idx)
            5'd0:  ch = 8'd0;
            5'd1:  ch = 8'd1;
            5'd2:  ch = 8'h2e;
            5'd3:  ch = 8'h20;
            5'd4:  ch = 8'h30;
            5'd5:  ch = 8'h31;
            5'd6:  ch = 8'h23;
            5'd7:  ch = 8'd7;
            5'd8:  ch = 8'h38;
            5'd9:  ch = 8'h39;
            5'd10: ch = 8'h32;
            5'd11: ch = 8'h33;
            5'd12: ch = 8'h34;
            5'd13: ch = 8'h35;
            5'd14: ch = 8'h36;
            5'd15: ch = 8'h37;
            5'd16: ch = 8'h28;
            5'd17: ch = 8'h3a;
            5'd18: ch = 8'h29;
            5'd19: ch = 8'h27;
            5'd20: ch = 8'h22;
            5'd21: ch = 8'h21;
            5'd22: ch = 8'h40;
            5'd23: ch = 8'h2d;
            5'd24: ch = 8'h24;
            5'd25: ch = 8'h2b;
            5'd26: ch = 8'h25;
            5'd27: ch = 8'd8;
            5'd28: ch = 8'h2a;
            5'd29: ch = 8'h3d;
            5'd30: ch = 8'h2f;
            5'd31: ch = 8'h3b;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/single_button_code_key_decoder.sv @@
// single-button code key decoder: press/release timing, code build and table translation
// One button sample is taken per word and every sample yields exactly one result word, in the
// cycle after it is accepted. A new sample is accepted in every cycle; the only stall comes
// from the single output register, which holds its word while m_tready is low, and s_tready
// follows m_tready in that case. Press and release lengths are counted in words, saturating at
// 255. The three timing registers are written through the cfg port and take effect on the
// next accepted word.
module single_button_code_key_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sbckd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbckd_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // button_down
    input  logic [sbckd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // key_valid, key_code, partial_code, mode_toggled, message_mode, numeric_table, zero pad
    output logic [sbckd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import sbckd_pkg::*;

    logic [CFG_W-1:0]   dot_period_reg;
    logic [CFG_W-1:0]   dash_period_reg;
    logic [CFG_W-1:0]   mode_switch_period_reg;

    logic [COUNT_W-1:0] press_count_reg, press_count_next;
    logic [COUNT_W-1:0] release_count_reg, release_count_next;
    logic [CODE_W-1:0]  building_code_reg, building_code_next;
    logic               table_select_reg, table_select_next;
    logic               display_mode_reg, display_mode_next;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               accept;
    logic               down;
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic               toggled;
    logic [CODE_W-1:0]  shifted_code;
    logic [CODE_W-1:0]  done_code;
    logic [CODE_W-1:0]  xlat;
    logic               finished;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign down     = s_tdata[0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_period_reg         <= DOT_PERIOD_RST;
            dash_period_reg        <= DASH_PERIOD_RST;
            mode_switch_period_reg <= MODE_SWITCH_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DOT_PERIOD:         dot_period_reg         <= cfg_wdata;
                CFG_DASH_PERIOD:        dash_period_reg        <= cfg_wdata;
                CFG_MODE_SWITCH_PERIOD: mode_switch_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        building_code_next = building_code_reg;
        table_select_next  = table_select_reg;
        display_mode_next  = display_mode_reg;
        key_valid          = 1'b0;
        key_code           = '0;
        toggled            = 1'b0;
        finished           = 1'b0;
        shifted_code       = building_code_reg;
        done_code          = KEY_NONE;
        xlat               = KEY_NONE;

        if (down) begin
            if (press_count_reg != COUNT_MAX) begin
                press_count_next = press_count_reg + 1'b1;
            end
            if (press_count_next == mode_switch_period_reg) begin
                display_mode_next = !display_mode_reg;
                toggled           = 1'b1;
            end
            release_count_next = '0;
        end else begin
            if (release_count_reg != COUNT_MAX) begin
                release_count_next = release_count_reg + 1'b1;
            end
            if (press_count_reg >= dot_period_reg && press_count_reg < mode_switch_period_reg) begin
                shifted_code = {building_code_reg[CODE_W-2:0],
                                press_count_reg >= dash_period_reg};
            end
            building_code_next = shifted_code;
            if (release_count_next >= dash_period_reg) begin
                done_code          = shifted_code;
                building_code_next = KEY_NONE;
                finished           = 1'b1;
            end
            press_count_next = '0;

            if (done_code < TABLE_SIZE) begin
                xlat = table_select_reg ? num_rom(done_code[TABLE_IDX_W-1:0])
                                        : alpha_rom(done_code[TABLE_IDX_W-1:0]);
            end else begin
                xlat = done_code;
            end

            if (finished && done_code != KEY_NONE) begin
                if (xlat == KEY_NUM_MODE) begin
                    table_select_next = 1'b1;
                end else if (xlat == KEY_ALPHA_MODE) begin
                    table_select_next = 1'b0;
                end else if (xlat != KEY_NONE) begin
                    key_valid = 1'b1;
                    key_code  = xlat;
                end
            end
        end

        m_tdata_next = {4'd0, table_select_next, display_mode_next, toggled,
                        building_code_next, key_code, key_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_count_reg   <= '0;
            release_count_reg <= '0;
            building_code_reg <= KEY_NONE;
            table_select_reg  <= 1'b0;
            display_mode_reg  <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                press_count_reg   <= press_count_next;
                release_count_reg <= release_count_next;
                building_code_reg <= building_code_next;
                table_select_reg  <= table_select_next;
                display_mode_reg  <= display_mode_next;
                m_tvalid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

@@ hdl/sbckd_checker.sv @@
// port-level checker for the code key decoder, bound to the top level
module sbckd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [sbckd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import sbckd_pkg::*;

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // no key means zero key code
    a_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("key code set without key valid");

    // finished character leaves an empty code behind
    a_key_clears_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[16:9] == KEY_NONE)
        else $error("partial code not empty after a key");

    // mode toggle comes on a press, a key on a release
    a_toggle_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[17] && m_tdata[0]))
        else $error("mode toggle and key in the same word");

endmodule

bind single_button_code_key_decoder sbckd_checker u_sbckd_checker (.*);

@@ tb/single_button_code_key_decoder_tb.sv @@
// testbench for the code key decoder: directed table, then random characters against a predictor
module single_button_code_key_decoder_tb;
    import sbckd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LEN_CAP     = 300;
    localparam int DRAIN_TICKS = 4;

    typedef struct packed {
        logic              numeric_table;
        logic              message_mode;
        logic              mode_toggled;
        logic [CODE_W-1:0] partial_code;
        logic [CODE_W-1:0] key_code;
        logic              key_valid;
    } key_word_t;

    typedef enum logic [1:0] {ROW_TICK, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic                 down;
        key_word_t            want;
    } plan_row_t;

    localparam key_word_t NO_WORD   = '0;
    localparam key_word_t IDLE_WORD = '{1'b0, 1'b0, 1'b0, KEY_NONE, 8'd0, 1'b0};

    localparam int PLAN_LEN = 34;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_TYPED, CFG_DOT_PERIOD, 8'd0, 1'b0, IDLE_WORD},
        '{ROW_TYPED, CFG_DOT_PERIOD, 8'd0, 1'b1, IDLE_WORD},
        '{ROW_CFG, CFG_DOT_PERIOD, 8'd1, 1'b0, NO_WORD},
        '{ROW_CFG, CFG_DASH_PERIOD, 8'd2, 1'b0, NO_WORD},
        '{ROW_CFG, CFG_MODE_SWITCH_PERIOD, 8'd4, 1'b0, NO_WORD},
        // dash, dot, then end of character switches to the numeric table
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        // two dots give a digit
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        // long press toggles the display mode, then an empty character
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        // write to an unused index must change nothing
        '{ROW_CFG, CFG_UNUSED, 8'hff, 1'b0, NO_WORD},
        // two dashes switch back to the alpha table
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        // one dot then end gives a period
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b1, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD},
        '{ROW_TICK, CFG_DOT_PERIOD, 8'd0, 1'b0, NO_WORD}
    };

    localparam logic [CODE_W-1:0] ALPHA_CHARS [TABLE_SIZE] = '{
        8'd0, KEY_NONE, ".", " ", "S", "Z", KEY_NUM_MODE, KEY_ALPHA_MODE,
        "T", "W", "A", "D", "G", "J", "M", "P",
        "U", "V", "X", "Y", "B", "C", "E", "F",
        "H", "I", "K", "L", "N", "O", "Q", "R"
    };

    localparam logic [CODE_W-1:0] NUM_CHARS [TABLE_SIZE] = '{
        8'd0, KEY_NONE, ".", " ", "0", "1", "#", KEY_ALPHA_MODE,
        "8", "9", "2", "3", "4", "5", "6", "7",
        "(", ":", ")", "'", "\"", "!", "@", "-",
        "$", "+", "%", 8'd8, "*", "=", "/", ";"
    };

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    single_button_code_key_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor copy of timing registers and decoder state
    logic [CFG_W-1:0]   dot_ticks    = DOT_PERIOD_RST;
    logic [CFG_W-1:0]   dash_ticks   = DASH_PERIOD_RST;
    logic [CFG_W-1:0]   toggle_ticks = MODE_SWITCH_PERIOD_RST;
    logic [COUNT_W-1:0] press_len    = '0;
    logic [COUNT_W-1:0] release_len  = '0;
    logic [CODE_W-1:0]  code_acc     = KEY_NONE;
    logic               numeric      = 1'b0;
    logic               message_view = 1'b0;

    key_word_t pending_keys [$];
    int        mismatches = 0;
    int        cycles     = 0;
    int        words_sent = 0;
    int        phase_end  = 0;
    int        src_idle   = 0;
    int        sink_idle  = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic key_word_t decode_tick(input logic down);
        key_word_t         r;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] ch;
        logic              done;
        r = '0;
        code = KEY_NONE;
        done = 1'b0;
        if (down) begin
            if (press_len != COUNT_MAX) press_len = press_len + 1'b1;
            if (press_len == toggle_ticks) begin
                message_view = ~message_view;
                r.mode_toggled = 1'b1;
            end
            release_len = '0;
        end else begin
            if (release_len != COUNT_MAX) release_len = release_len + 1'b1;
            if (press_len >= dot_ticks && press_len < toggle_ticks)
                code_acc = {code_acc[CODE_W-2:0], press_len >= dash_ticks};
            if (release_len >= dash_ticks) begin
                code = code_acc;
                code_acc = KEY_NONE;
                done = 1'b1;
            end
            press_len = '0;
            if (done && code != KEY_NONE) begin
                ch = code;
                if (code < TABLE_SIZE)
                    ch = numeric ? NUM_CHARS[code[TABLE_IDX_W-1:0]]
                                 : ALPHA_CHARS[code[TABLE_IDX_W-1:0]];
                if (ch == KEY_NUM_MODE) begin
                    numeric = 1'b1;
                end else if (ch == KEY_ALPHA_MODE) begin
                    numeric = 1'b0;
                end else if (ch != KEY_NONE) begin
                    r.key_valid = 1'b1;
                    r.key_code = ch;
                end
            end
        end
        r.partial_code = code_acc;
        r.message_mode = message_view;
        r.numeric_table = numeric;
        return r;
    endfunction

    function automatic int span(int lo, int hi);
        if (lo < 1) lo = 1;
        if (lo > LEN_CAP) lo = LEN_CAP;
        if (hi < lo) hi = lo;
        if (hi > LEN_CAP) hi = LEN_CAP;
        return $urandom_range(hi, lo);
    endfunction

    task automatic send_word(input logic down, input logic typed, input key_word_t want);
        key_word_t p;
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-1){1'b0}}, down};
        do @(posedge aclk); while (!s_tready);
        p = decode_tick(down);
        pending_keys.push_back(typed ? want : p);
        words_sent++;
    endtask

    task automatic send_run(input logic down, input int n);
        repeat (n) if (words_sent < phase_end) send_word(down, 1'b0, NO_WORD);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (DRAIN_TICKS) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DOT_PERIOD:         dot_ticks = val;
            CFG_DASH_PERIOD:        dash_ticks = val;
            CFG_MODE_SWITCH_PERIOD: toggle_ticks = val;
            default: ;
        endcase
    endtask

    task automatic random_char;
        int k;
        int len;
        int roll;
        int d;
        int a;
        int m;
        d = int'(dot_ticks);
        a = int'(dash_ticks);
        m = int'(toggle_ticks);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(0, 1)), 1'b0, NO_WORD);
        end else begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6)       len = span(m, m);
                else if (roll < 9)  len = span(m + 1, m + 4);
                else if (roll < 11) len = LEN_CAP;
                else if (roll < 55) len = span(d, a - 1);
                else                len = span(a, m - 1);
                send_run(1'b1, len);
                if (i < k - 1) send_run(1'b0, span(1, a - 1));
            end
            if ($urandom_range(0, 99) < 5) send_run(1'b0, LEN_CAP);
            else                           send_run(1'b0, span(a, a + 3));
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] a,
                             input logic [CFG_W-1:0] m, input int budget);
        drain;
        set_reg(CFG_DOT_PERIOD, d);
        set_reg(CFG_DASH_PERIOD, a);
        set_reg(CFG_MODE_SWITCH_PERIOD, m);
        cfg_wr_en <= 1'b0;
        phase_end = words_sent + budget;
        while (words_sent < phase_end) random_char;
    endtask

    // result side: random stall and compare against the oldest expectation
    initial begin
        key_word_t got;
        key_word_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[$bits(key_word_t)-1:0];
                if (pending_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: got %h", got);
                end else begin
                    want = pending_keys.pop_front();
                    if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                        got.partial_code !== want.partial_code ||
                        got.mode_toggled !== want.mode_toggled ||
                        got.message_mode !== want.message_mode ||
                        got.numeric_table !== want.numeric_table) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want kv=%0d key=%h part=%h tog=%0d msg=%0d num=%0d",
                                     want.key_valid, want.key_code, want.partial_code,
                                     want.mode_toggled, want.message_mode, want.numeric_table,
                                     "\n          got  kv=%0d key=%h part=%h tog=%0d msg=%0d num=%0d",
                                     got.key_valid, got.key_code, got.partial_code,
                                     got.mode_toggled, got.message_mode, got.numeric_table);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        logic in_writes;
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] a;
        in_writes = 1'b0;
        src_idle = 29;
        sink_idle = 53;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_CFG) begin
                if (!in_writes) drain;
                set_reg(PLAN[i].idx, PLAN[i].val);
                in_writes = 1'b1;
            end else begin
                if (in_writes) cfg_wr_en <= 1'b0;
                in_writes = 1'b0;
                send_word(PLAN[i].down, PLAN[i].kind == ROW_TYPED, PLAN[i].want);
            end
        end

        run_phase(DOT_PERIOD_RST, DASH_PERIOD_RST, MODE_SWITCH_PERIOD_RST, 250);
        run_phase(8'd1, 8'd2, 8'd4, 150);
        run_phase(8'd1, 8'd1, 8'd1, 80);

        src_idle = 53;
        sink_idle = 29;
        run_phase(8'd0, 8'd0, 8'd0, 80);
        run_phase(8'd0, 8'd3, 8'd6, 80);
        d = CFG_W'($urandom_range(1, 4));
        a = CFG_W'(d + $urandom_range(1, 6));
        run_phase(d, a, CFG_W'(a + $urandom_range(1, 12)), 150);

        src_idle = 0;
        sink_idle = 0;
        run_phase(8'd255, 8'd255, 8'd255, 300);
        run_phase(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 20)),
                  CFG_W'($urandom_range(0, 20)), 150);

        s_tvalid <= 1'b0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_keys.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
